FILE: design/multi_axis_servo_ramp_unit_defines.svh
// Assertion macros for the servo ramp unit checker
`ifndef MULTI_AXIS_SERVO_RAMP_UNIT_DEFINES_SVH
`define MULTI_AXIS_SERVO_RAMP_UNIT_DEFINES_SVH

// check a property with reset masking
`define MSRA_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check a property that also holds across reset
`define MSRA_CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: design/msra_pkg.sv
// Shared types, constants and helpers for the servo ramp unit
`default_nettype none
package msra_pkg;
    localparam int AXES      = 5;
    localparam int NCH       = 5;
    localparam int LIVE_AXES = (AXES < NCH) ? AXES : NCH;
    localparam int ANG_W     = 17;
    localparam int RATE_W    = 18;
    localparam int REG_W     = 13;
    localparam int PW        = 12;
    localparam int IDX_W     = 3;
    localparam int DIV_N     = 30;
    localparam int DIVS_W    = 17;

    localparam logic [IDX_W-1:0] BASE_AXIS    = 3'd0;
    localparam logic [IDX_W-1:0] WRIST_AXIS   = 3'd3;
    localparam logic [IDX_W-1:0] GRIPPER_AXIS = 3'd4;
    localparam logic [IDX_W-1:0] LAST_LIVE    = IDX_W'(LIVE_AXES - 1);
    localparam logic [IDX_W-1:0] LAST_CH      = IDX_W'(NCH - 1);

    localparam logic [DIVS_W-1:0] SPAN_BASE  = 17'd270;
    localparam logic [DIVS_W-1:0] SPAN_OTHER = 17'd180;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SET_ALL = 2'd1;
    localparam logic [1:0] CMD_SET_ONE = 2'd2;

    localparam logic [2:0] REG_STEP     = 3'd0;
    localparam logic [2:0] REG_MANUAL   = 3'd1;
    localparam logic [2:0] REG_TOL      = 3'd2;
    localparam logic [2:0] REG_SPMIN    = 3'd3;
    localparam logic [2:0] REG_SPMAX    = 3'd4;
    localparam logic [2:0] REG_LPMIN    = 3'd5;
    localparam logic [2:0] REG_LPMAX    = 3'd6;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [2:0]       axis;
        logic [ANG_W-1:0] target_0;
        logic [ANG_W-1:0] target_1;
        logic [ANG_W-1:0] target_2;
        logic [ANG_W-1:0] target_3;
        logic [ANG_W-1:0] target_4;
    } in_t;

    typedef struct packed {
        logic [PW-1:0] pulse_0;
        logic [PW-1:0] pulse_1;
        logic [PW-1:0] pulse_2;
        logic [PW-1:0] pulse_3;
        logic [PW-1:0] pulse_4;
        logic          moving;
        logic          arrived;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [DIV_N-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_RATE, ST_SET1, ST_MOVE,
        ST_PULSE, ST_DSTART, ST_DWAIT, ST_FIN
    } state_t;

    function automatic logic [RATE_W-1:0] mag18(input logic signed [RATE_W-1:0] v);
        logic [RATE_W-1:0] r;
        r = v[RATE_W-1] ? RATE_W'(-v) : RATE_W'(v);
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: design/msra_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module msra_div
    import msra_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    localparam int CNT_W = $clog2(DIV_N + 1);

    logic [DIV_N-1:0]  dq_reg, dq_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   rem_sub;

    always_comb begin
        rem_sh    = {rem_reg, dq_reg[DIV_N-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dq_next   = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!rem_sub[DIVS_W]) begin
                rem_next = rem_sub[DIVS_W-1:0];
                dq_next  = {dq_reg[DIV_N-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIVS_W-1:0];
                dq_next  = {dq_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;
endmodule
`default_nettype wire

FILE: design/multi_axis_servo_ramp_unit.sv
// Servo ramp unit: sequencer, axis state and pulse mapping around a serial divider
//
// Takes one command at a time and returns one result per command. Axes are
// handled one per cycle, except where an axis waits on the shared bit-serial
// divider (30 quotient bits): every pulse width goes through it, and so does
// each synchronized rate unless the largest move is zero or below the step.
// A tick runs a move pass and a pulse pass; a set-one command sets one axis
// and runs the pulse pass; a set-all command replaces the move pass with a
// scan pass and a rate pass. A finished result waits in the output register
// while the next command is already being taken.
`default_nettype none
module multi_axis_servo_ramp_unit
    import msra_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_t              s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_t                  m_data,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [REG_W-1:0] cfg_wdata
);
    state_t state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    in_t               in_reg, in_next;
    logic [ANG_W-1:0]  maxd_reg, maxd_next;
    logic [DIV_N-1:0]  prod_reg, prod_next;
    logic              neg_reg, neg_next;
    logic              mode_reg, mode_next;
    logic              moving_reg, moving_next;
    logic              arrived_reg, arrived_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic [REG_W-1:0] step_reg, manual_reg, tol_reg;
    logic [PW-1:0]    spmin_reg, spmax_reg, lpmin_reg, lpmax_reg;

    logic [ANG_W-1:0]         cur_mem [NCH];
    logic [ANG_W-1:0]         tgt_mem [NCH];
    logic signed [RATE_W-1:0] rate_mem [NCH];
    logic [PW-1:0]            pulse_reg [NCH];

    logic                     cur_we, tgt_we, rate_we, pulse_we;
    logic [ANG_W-1:0]         cur_wd, tgt_wd;
    logic signed [RATE_W-1:0] rate_wd;
    logic [PW-1:0]            pulse_wd;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [ANG_W-1:0]         cur, tgt, in_tgt, t1, ang_cl, span256;
    logic signed [RATE_W-1:0] rate, diff, sdiff, kk, qs;
    logic [RATE_W-1:0]        mdiff, msdiff, mrate;
    logic [DIVS_W-1:0]        span;
    logic [PW-1:0]            pmin, pmax, q12;
    logic signed [PW:0]       pdiff;
    logic [PW-1:0]            pmag;
    logic [8:0]               deg;
    logic                     last_adv;

    msra_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_comb begin
        cur  = cur_mem[idx_reg];
        tgt  = tgt_mem[idx_reg];
        rate = rate_mem[idx_reg];
        unique case (idx_reg)
            3'd0:    in_tgt = in_reg.target_0;
            3'd1:    in_tgt = in_reg.target_1;
            3'd2:    in_tgt = in_reg.target_2;
            3'd3:    in_tgt = in_reg.target_3;
            default: in_tgt = in_reg.target_4;
        endcase
        diff   = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        sdiff  = $signed({1'b0, in_tgt}) - $signed({1'b0, cur});
        mdiff  = mag18(diff);
        msdiff = mag18(sdiff);
        mrate  = mag18(rate);
        t1     = in_reg.target_0;
        kk     = (idx_reg == GRIPPER_AXIS) ? $signed({4'b0, manual_reg, 1'b0})
                                           : $signed({5'b0, manual_reg});
        span   = (idx_reg == BASE_AXIS) ? SPAN_BASE : SPAN_OTHER;
        span256 = ANG_W'({span, 8'b0});
        ang_cl = (cur > span256) ? span256 : cur;
        deg    = ang_cl[16:8];
        if (idx_reg == WRIST_AXIS || idx_reg == GRIPPER_AXIS) begin
            pmin = spmin_reg;
            pmax = spmax_reg;
        end else begin
            pmin = lpmin_reg;
            pmax = lpmax_reg;
        end
        pdiff = $signed({1'b0, pmax}) - $signed({1'b0, pmin});
        pmag  = pdiff[PW] ? PW'(-pdiff) : PW'(pdiff);
        qs    = neg_reg ? -$signed(drsp.quotient[RATE_W-1:0])
                        : $signed(drsp.quotient[RATE_W-1:0]);
        q12   = neg_reg ? PW'(-drsp.quotient[PW-1:0]) : drsp.quotient[PW-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        in_next      = in_reg;
        maxd_next    = maxd_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        mode_next    = mode_reg;
        moving_next  = moving_reg;
        arrived_next = arrived_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cur_we = 1'b0; tgt_we = 1'b0; rate_we = 1'b0; pulse_we = 1'b0;
        cur_wd = tgt; tgt_wd = in_tgt; rate_wd = diff; pulse_wd = '0;
        dreq.start    = 1'b0;
        dreq.dividend = prod_reg;
        dreq.divisor  = mode_reg ? span : maxd_reg;
        s_ready  = 1'b0;
        last_adv = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next      = s_data;
                    idx_next     = '0;
                    maxd_next    = '0;
                    moving_next  = 1'b0;
                    arrived_next = 1'b1;
                    unique case (s_data.cmd)
                        CMD_TICK:    state_next = ST_MOVE;
                        CMD_SET_ALL: state_next = ST_SCAN;
                        CMD_SET_ONE: begin
                            state_next = ST_SET1;
                            idx_next   = s_data.axis;
                        end
                        default:     state_next = ST_PULSE;
                    endcase
                end
            end
            ST_SCAN: begin
                tgt_we = 1'b1;
                if (msdiff > {1'b0, maxd_reg}) maxd_next = msdiff[ANG_W-1:0];
                if (idx_reg == LAST_LIVE) begin
                    idx_next   = '0;
                    state_next = ST_RATE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RATE: begin
                if (maxd_reg == '0 || maxd_reg < {4'b0, step_reg}) begin
                    rate_we = 1'b1;
                    if (idx_reg == LAST_LIVE) begin
                        idx_next   = '0;
                        state_next = ST_PULSE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    prod_next  = DIV_N'(mdiff[ANG_W-1:0]) * DIV_N'(step_reg);
                    neg_next   = diff[RATE_W-1];
                    mode_next  = 1'b0;
                    state_next = ST_DSTART;
                end
            end
            ST_SET1: begin
                if (idx_reg <= LAST_LIVE) begin
                    tgt_we  = 1'b1;
                    tgt_wd  = t1;
                    rate_we = 1'b1;
                    rate_wd = (t1 > cur) ? kk : -kk;
                end
                idx_next   = '0;
                state_next = ST_PULSE;
            end
            ST_MOVE: begin
                cur_we = 1'b1;
                if (mdiff > mrate && mrate != '0) begin
                    cur_wd      = ANG_W'($signed({1'b0, cur}) + rate);
                    moving_next = 1'b1;
                end
                if (idx_reg == LAST_LIVE) begin
                    idx_next   = '0;
                    state_next = ST_PULSE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PULSE: begin
                if (idx_reg > LAST_LIVE) begin
                    pulse_we = 1'b1;
                    last_adv = 1'b1;
                end else begin
                    if (mdiff > {5'b0, tol_reg}) arrived_next = 1'b0;
                    prod_next  = DIV_N'(deg) * DIV_N'(pmag);
                    neg_next   = pdiff[PW];
                    mode_next  = 1'b1;
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                dreq.start = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (drsp.done) begin
                    if (!mode_reg) begin
                        rate_we = 1'b1;
                        rate_wd = qs;
                        if (idx_reg == LAST_LIVE) begin
                            idx_next   = '0;
                            state_next = ST_PULSE;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_RATE;
                        end
                    end else begin
                        pulse_we = 1'b1;
                        pulse_wd = pmin + q12;
                        last_adv = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.pulse_0 = pulse_reg[0];
                    m_data_next.pulse_1 = pulse_reg[1];
                    m_data_next.pulse_2 = pulse_reg[2];
                    m_data_next.pulse_3 = pulse_reg[3];
                    m_data_next.pulse_4 = pulse_reg[4];
                    m_data_next.moving  = moving_reg;
                    m_data_next.arrived = arrived_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (last_adv) begin
            if (idx_reg == LAST_CH) begin
                idx_next   = '0;
                state_next = ST_FIN;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_PULSE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= 13'd205;
            manual_reg  <= 13'd256;
            tol_reg     <= 13'd128;
            spmin_reg   <= 12'd500;
            spmax_reg   <= 12'd2400;
            lpmin_reg   <= 12'd500;
            lpmax_reg   <= 12'd2500;
            for (int i = 0; i < NCH; i++) begin
                cur_mem[i]  <= '0;
                tgt_mem[i]  <= '0;
                rate_mem[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_STEP:   step_reg   <= cfg_wdata;
                    REG_MANUAL: manual_reg <= cfg_wdata;
                    REG_TOL:    tol_reg    <= cfg_wdata;
                    REG_SPMIN:  spmin_reg  <= cfg_wdata[PW-1:0];
                    REG_SPMAX:  spmax_reg  <= cfg_wdata[PW-1:0];
                    REG_LPMIN:  lpmin_reg  <= cfg_wdata[PW-1:0];
                    REG_LPMAX:  lpmax_reg  <= cfg_wdata[PW-1:0];
                    default: ;
                endcase
            end
            if (cur_we)  cur_mem[idx_reg]  <= cur_wd;
            if (tgt_we)  tgt_mem[idx_reg]  <= tgt_wd;
            if (rate_we) rate_mem[idx_reg] <= rate_wd;
        end
        in_reg      <= in_next;
        maxd_reg    <= maxd_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        mode_reg    <= mode_next;
        moving_reg  <= moving_next;
        arrived_reg <= arrived_next;
        m_data_reg  <= m_data_next;
        if (pulse_we) pulse_reg[idx_reg] <= pulse_wd;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

FILE: design/msra_checker.sv
// Port-level checker for the servo ramp unit and its bind
`default_nettype none
`include "multi_axis_servo_ramp_unit_defines.svh"
module msra_checker
    import msra_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire in_t              s_data,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire out_t             m_data
);
    `MSRA_CHK(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `MSRA_CHK(a_out_stable, m_valid && !m_ready |=> $stable(m_data), "stalled result changed")
    `MSRA_CHK(a_in_stable, s_valid && !s_ready |=> s_valid && $stable(s_data), "input changed while waiting")
    `MSRA_CHK(a_busy_after_in, s_valid && s_ready |=> !s_ready, "second transfer taken while busy")
    `MSRA_CHK_RST(a_rst_empty, !aresetn |=> !m_valid, "result valid after reset")
endmodule

bind multi_axis_servo_ramp_unit msra_checker u_msra_checker (.*);
`default_nettype wire
